FILE: rtl/lru_cache_table_with_expiry_core_defines.svh
// Assertion macros for the cache table core
`ifndef LRU_CACHE_TABLE_WITH_EXPIRY_CORE_DEFINES_SVH
`define LRU_CACHE_TABLE_WITH_EXPIRY_CORE_DEFINES_SVH
`ifndef SYNTH
`define LCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCT_ASSERT(label, clk, rst_n, prop, msg)
`define LCT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/lct_pkg.sv
`default_nettype none
package lct_pkg;
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ROOM   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_STALE     = 3'd2,
    ST_ADDED     = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_EVICTED   = 3'd5,
    ST_NOT_FULL  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_APPLY = 2'd2,
    FSM_OUT  = 2'd3
  } fsm_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_REQ  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RESP = 1'b1;
  localparam logic [15:0] MaxReqReset  = 16'd2000;
  localparam logic [23:0] MaxRespReset = 24'd102400;
  localparam logic [9:0]  MsPerS = 10'd1000;
  localparam int unsigned SeqW = 48;
  localparam int unsigned TimeW = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] request_key;
    logic [15:0] req_bytes;
    logic [23:0] resp_bytes;
    logic [31:0] lifetime_s;
    logic [39:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic       evicted;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: rtl/lct_ctrl.sv
`default_nettype none
module lct_ctrl
  import lct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:  if (in_valid_i) state_d = FSM_SCAN;
      FSM_SCAN:  if (sts_i.scan_last) state_d = FSM_APPLY;
      FSM_APPLY: state_d = FSM_OUT;
      FSM_OUT:   if (out_ready_i) state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == FSM_IDLE);
    out_valid_o = (state_q == FSM_OUT);
    cmd_o = '0;
    cmd_o.load = (state_q == FSM_IDLE) && in_valid_i;
    cmd_o.scan_start = cmd_o.load;
    cmd_o.scan_step = (state_q == FSM_SCAN);
    cmd_o.apply = (state_q == FSM_APPLY);
  end
endmodule
`default_nettype wire

FILE: rtl/lct_dp.sv
`default_nettype none
module lct_dp
  import lct_pkg::*;
#(
  parameter int unsigned Entries = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  logic      cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_word_t out_word_o,
  output logic [$clog2(Entries+1)-1:0] occ_o
);
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned OccW = $clog2(Entries + 1);
  localparam logic [OccW-1:0] EntriesOcc = OccW'(Entries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  logic [Entries-1:0] valid_q, valid_d;
  logic [63:0]     key_mem  [Entries];
  logic [15:0]     len_mem  [Entries];
  logic [SeqW-1:0] use_mem  [Entries];
  logic [TimeW-1:0] at_mem  [Entries];
  logic [31:0]     life_mem [Entries];

  in_word_t        req_q;
  logic [15:0]     max_req_q;
  logic [23:0]     max_resp_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [IdxW-1:0] idx_q;
  logic            match_q, match_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            lru_q, lru_d;
  logic [IdxW-1:0] lru_idx_q, lru_idx_d;
  logic [SeqW-1:0] lru_use_q, lru_use_d;
  logic            stale_q, stale_d;
  out_word_t       out_q, out_d;

  logic [TimeW-1:0] age;
  logic [41:0]      limit;
  logic             is_match;
  logic             too_req, too_resp;
  logic [IdxW-1:0]  tgt;
  logic             we;
  logic [SeqW-1:0]  seq_inc;

  assign sts_o.scan_last = (idx_q == LastIdx);
  assign out_word_o = out_q;
  assign occ_o = occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q  <= MaxReqReset;
      max_resp_q <= MaxRespReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_REQ:  max_req_q  <= cfg_data_i[15:0];
        CFG_MAX_RESP: max_resp_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    age = req_q.now_ms - at_mem[idx_q];
    limit = 42'(life_mem[idx_q]) * 42'(MsPerS);
    is_match = valid_q[idx_q] && (len_mem[idx_q] == req_q.req_bytes)
               && (key_mem[idx_q] == req_q.request_key);
    match_d = match_q; match_idx_d = match_idx_q; stale_d = stale_q;
    free_d = free_q; free_idx_d = free_idx_q;
    lru_d = lru_q; lru_idx_d = lru_idx_q; lru_use_d = lru_use_q;
    if (cmd_i.scan_start) begin
      match_d = 1'b0; free_d = 1'b0; lru_d = 1'b0;
      match_idx_d = '0; free_idx_d = '0; lru_idx_d = '0; stale_d = 1'b0;
      lru_use_d = '0;
    end else if (cmd_i.scan_step) begin
      if (is_match && !match_q) begin
        match_d = 1'b1;
        match_idx_d = idx_q;
        stale_d = (life_mem[idx_q] != '0) && (42'(age) > limit);
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_d = 1'b1;
        free_idx_d = idx_q;
      end
      if (valid_q[idx_q] && (!lru_q || use_mem[idx_q] < lru_use_q)) begin
        lru_d = 1'b1;
        lru_idx_d = idx_q;
        lru_use_d = use_mem[idx_q];
      end
    end
  end

  always_comb begin
    too_req  = req_q.req_bytes > max_req_q;
    too_resp = req_q.resp_bytes > max_resp_q;
    seq_inc  = (seq_q == '1) ? seq_q : seq_q + SeqW'(1);
    valid_d = valid_q;
    occ_d = occ_q;
    seq_d = seq_q;
    out_d = out_q;
    tgt = '0;
    we = 1'b0;
    if (cmd_i.apply) begin
      out_d = '{status: ST_MISS, slot: 4'd0, evicted: 1'b0};
      unique case (kind_e'(req_q.kind))
        KIND_LOOKUP: begin
          if (match_q && stale_q) begin
            out_d.status = ST_STALE;
          end else if (match_q) begin
            seq_d = seq_inc;
            out_d.status = ST_HIT;
            out_d.slot = 4'(match_idx_q);
          end
        end
        KIND_INSERT: begin
          if (too_req || too_resp) begin
            out_d.status = ST_TOO_LARGE;
          end else begin
            if (occ_q < EntriesOcc && free_q) begin
              tgt = free_idx_q;
              occ_d = occ_q + OccW'(1);
            end else if (lru_q) begin
              tgt = lru_idx_q;
              out_d.evicted = 1'b1;
            end else begin
              tgt = free_idx_q;
            end
            we = 1'b1;
            seq_d = seq_inc;
            valid_d[tgt] = 1'b1;
            out_d.status = ST_ADDED;
            out_d.slot = 4'(tgt);
          end
        end
        KIND_ROOM: begin
          if (too_req) begin
            out_d.status = ST_TOO_LARGE;
          end else if (occ_q >= EntriesOcc) begin
            if (lru_q) begin
              valid_d[lru_idx_q] = 1'b0;
              occ_d = occ_q - OccW'(1);
              out_d.evicted = 1'b1;
              out_d.slot = 4'(lru_idx_q);
            end
            out_d.status = ST_EVICTED;
          end else begin
            out_d.status = ST_NOT_FULL;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      seq_q   <= '0;
      idx_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      lru_q   <= 1'b0;
      stale_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      seq_q   <= seq_d;
      match_q <= match_d;
      free_q  <= free_d;
      lru_q   <= lru_d;
      stale_q <= stale_d;
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step && idx_q != LastIdx) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_word_i;
    end
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    lru_idx_q   <= lru_idx_d;
    lru_use_q   <= lru_use_d;
    out_q       <= out_d;
    if (we) begin
      key_mem[tgt]  <= req_q.request_key;
      len_mem[tgt]  <= req_q.req_bytes;
      use_mem[tgt]  <= seq_d;
      at_mem[tgt]   <= req_q.now_ms;
      life_mem[tgt] <= req_q.lifetime_s;
    end else if (cmd_i.apply && kind_e'(req_q.kind) == KIND_LOOKUP
                 && match_q && !stale_q) begin
      use_mem[match_idx_q] <= seq_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lru_cache_table_with_expiry_core.sv
// An accepted input word is loaded, the slots are scanned, the result is
// applied and held until taken; no new word is taken before then. The scan
// visits one slot a cycle through a single compare and age-check unit.
// Reset: asynchronous, active low; clears all slot valid bits, occupancy,
// sequence counter and restores the length limits. No clearing pass.
`default_nettype none
`include "lru_cache_table_with_expiry_core_defines.svh"
module lru_cache_table_with_expiry_core
  import lct_pkg::*;
#(
  parameter int unsigned Entries = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [$clog2(Entries+1)-1:0] occ;

  assign cfg_ready_o = 1'b1;

  lct_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lct_dp #(.Entries(Entries)) u_dp (
    .clk_i, .rst_ni, .in_word_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_word_o, .occ_o(occ)
  );

  `LCT_ASSERT(a_occ_range, clk_i, rst_ni, occ <= ($clog2(Entries+1))'(Entries), "occupancy overflow")
  `LCT_ASSERT(a_hold_busy, clk_i, rst_ni, out_valid_o |-> !in_ready_o, "ready while result pending")
  `LCT_ASSERT(a_out_after, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
endmodule
`default_nettype wire
